[sv/owb_pkg.sv]
// owb_pkg: shared types, codes and reset values for the 1-Wire bus master
// no dependencies; imported by owb_regs, owb_core and onewire_bus_master
`timescale 1ns / 1ps

package owb_pkg;

  // configuration register file geometry
  localparam int unsigned CfgWidth      = 10;
  localparam int unsigned CfgIdxWidth   = 3;
  localparam int unsigned DefCountWidth = 10;

  // register reset values
  localparam logic [CfgWidth-1:0] PreResetReleaseRst = 10'd10;
  localparam logic [CfgWidth-1:0] ResetLowRst        = 10'd600;
  localparam logic [CfgWidth-1:0] PresenceWaitRst    = 10'd460;
  localparam logic [CfgWidth-1:0] WriteLowRst        = 10'd5;
  localparam logic [CfgWidth-1:0] SlotHoldRst        = 10'd60;
  localparam logic [CfgWidth-1:0] RecoveryRst        = 10'd1;
  localparam logic [CfgWidth-1:0] ReadLowRst         = 10'd2;

  // register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_PRE_RESET_RELEASE = 3'd0,
    REG_RESET_LOW         = 3'd1,
    REG_PRESENCE_WAIT     = 3'd2,
    REG_WRITE_LOW         = 3'd3,
    REG_SLOT_HOLD         = 3'd4,
    REG_RECOVERY          = 3'd5,
    REG_READ_LOW          = 3'd6
  } owb_reg_e;

  // command codes
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_RESET = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_READ  = 2'd3
  } owb_func_e;

  // bus sequencer phases, one-hot
  typedef enum logic [9:0] {
    PH_IDLE    = 10'b00_0000_0001,
    PH_R_PRE   = 10'b00_0000_0010,
    PH_R_LOW   = 10'b00_0000_0100,
    PH_R_WAIT  = 10'b00_0000_1000,
    PH_W_LOW   = 10'b00_0001_0000,
    PH_W_HOLD  = 10'b00_0010_0000,
    PH_W_REC   = 10'b00_0100_0000,
    PH_RD_REC  = 10'b00_1000_0000,
    PH_RD_LOW  = 10'b01_0000_0000,
    PH_RD_TAIL = 10'b10_0000_0000
  } owb_phase_e;

  // timing configuration seen by the sequencer
  typedef struct packed {
    logic [CfgWidth-1:0] pre_reset_release;
    logic [CfgWidth-1:0] reset_low;
    logic [CfgWidth-1:0] presence_wait;
    logic [CfgWidth-1:0] write_low;
    logic [CfgWidth-1:0] slot_hold;
    logic [CfgWidth-1:0] recovery;
    logic [CfgWidth-1:0] read_low;
  } owb_cfg_t;

  // one result transaction
  typedef struct packed {
    logic       pull_low;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       presence;
    logic       rejected;
  } owb_res_t;

endpackage

[sv/owb_regs.sv]
// owb_regs: timing configuration registers of the 1-Wire bus master
// depends on owb_pkg
`timescale 1ns / 1ps

module owb_regs import owb_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_wdata_i,
  output owb_cfg_t               cfg_o
);

  owb_cfg_t cfg_q;

  // write by index, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pre_reset_release <= PreResetReleaseRst;
      cfg_q.reset_low         <= ResetLowRst;
      cfg_q.presence_wait     <= PresenceWaitRst;
      cfg_q.write_low         <= WriteLowRst;
      cfg_q.slot_hold         <= SlotHoldRst;
      cfg_q.recovery          <= RecoveryRst;
      cfg_q.read_low          <= ReadLowRst;
    end else if (cfg_we_i) begin
      unique case (owb_reg_e'(cfg_idx_i))
        REG_PRE_RESET_RELEASE: cfg_q.pre_reset_release <= cfg_wdata_i;
        REG_RESET_LOW:         cfg_q.reset_low         <= cfg_wdata_i;
        REG_PRESENCE_WAIT:     cfg_q.presence_wait     <= cfg_wdata_i;
        REG_WRITE_LOW:         cfg_q.write_low         <= cfg_wdata_i;
        REG_SLOT_HOLD:         cfg_q.slot_hold         <= cfg_wdata_i;
        REG_RECOVERY:          cfg_q.recovery          <= cfg_wdata_i;
        REG_READ_LOW:          cfg_q.read_low          <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/owb_core.sv]
// owb_core: 1-Wire phase sequencer, tick counter, bit shifter and status
// depends on owb_pkg; timing comes from owb_regs
`timescale 1ns / 1ps

module owb_core import owb_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = DefCountWidth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       acc_i,
  input  logic [1:0] func_i,
  input  logic [7:0] tx_byte_i,
  input  logic       line_level_i,
  input  owb_cfg_t   cfg_i,
  output owb_res_t   res_o
);

  localparam int unsigned DurWidth = (COUNT_WIDTH > CfgWidth) ? COUNT_WIDTH : CfgWidth;
  localparam logic [COUNT_WIDTH-1:0] CntMax    = '1;
  localparam logic [DurWidth-1:0]    CntMaxExt = DurWidth'(CntMax);

  owb_phase_e             phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] tick_q, tick_d;
  logic [2:0]             bit_q, bit_d;
  logic [7:0]             shift_q, shift_d;
  logic                   pres_q, pres_d;
  logic [7:0]             rx_q, rx_d;

  logic [CfgWidth-1:0]    raw_dur;
  logic [CfgWidth-1:0]    nz_dur;
  logic [DurWidth-1:0]    dur;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   phase_end;
  logic [7:0]             sampled;
  logic                   busy_in;
  logic                   is_start;
  logic                   done;
  logic                   pull_low;

  // duration of the current phase, zero taken as one, clipped to counter range
  always_comb begin
    unique case (phase_q)
      PH_R_PRE:   raw_dur = cfg_i.pre_reset_release;
      PH_R_LOW:   raw_dur = cfg_i.reset_low;
      PH_R_WAIT:  raw_dur = cfg_i.presence_wait;
      PH_W_LOW:   raw_dur = cfg_i.write_low;
      PH_W_HOLD:  raw_dur = cfg_i.slot_hold;
      PH_W_REC:   raw_dur = cfg_i.recovery;
      PH_RD_REC:  raw_dur = cfg_i.recovery;
      PH_RD_LOW:  raw_dur = cfg_i.read_low;
      PH_RD_TAIL: raw_dur = cfg_i.slot_hold;
      default:    raw_dur = CfgWidth'(1);
    endcase
    nz_dur = (raw_dur == '0) ? CfgWidth'(1) : raw_dur;
    dur    = (DurWidth'(nz_dur) > CntMaxExt) ? CntMaxExt : DurWidth'(nz_dur);
  end

  // saturating tick count and end of phase
  assign cnt_inc   = (tick_q != CntMax) ? tick_q + COUNT_WIDTH'(1) : tick_q;
  assign phase_end = (DurWidth'(cnt_inc) >= dur);

  // read bit enters from the top on the first tick of the slot tail
  assign sampled = ((phase_q == PH_RD_TAIL) && (tick_q == '0)) ?
                   {line_level_i, shift_q[7:1]} : shift_q;

  assign busy_in  = (phase_q != PH_IDLE);
  assign is_start = (owb_func_e'(func_i) != FUNC_TICK);

  // next state for one transaction
  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    pres_d  = pres_q;
    rx_d    = rx_q;
    done    = 1'b0;
    if (busy_in) begin
      shift_d = sampled;
      tick_d  = cnt_inc;
      if (phase_end) begin
        tick_d = '0;
        unique case (phase_q)
          PH_R_PRE:  phase_d = PH_R_LOW;
          PH_R_LOW:  phase_d = PH_R_WAIT;
          PH_R_WAIT: begin
            pres_d  = ~line_level_i;
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
          PH_W_LOW:  phase_d = PH_W_HOLD;
          PH_W_HOLD: begin
            shift_d = {1'b0, shift_q[7:1]};
            phase_d = PH_W_REC;
          end
          PH_W_REC: begin
            if (bit_q != 3'd7) begin
              bit_d   = bit_q + 3'd1;
              phase_d = PH_W_LOW;
            end else begin
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
          end
          PH_RD_REC: phase_d = PH_RD_LOW;
          PH_RD_LOW: phase_d = PH_RD_TAIL;
          PH_RD_TAIL: begin
            if (bit_q != 3'd7) begin
              bit_d   = bit_q + 3'd1;
              phase_d = PH_RD_REC;
            end else begin
              rx_d    = sampled;
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end else if (is_start) begin
      bit_d  = 3'd0;
      tick_d = '0;
      unique case (owb_func_e'(func_i))
        FUNC_RESET: begin
          pres_d  = 1'b0;
          phase_d = (cfg_i.pre_reset_release == '0) ? PH_R_LOW : PH_R_PRE;
        end
        FUNC_WRITE: begin
          shift_d = tx_byte_i;
          phase_d = PH_W_LOW;
        end
        FUNC_READ: begin
          shift_d = 8'h00;
          phase_d = PH_RD_REC;
        end
        default: ;
      endcase
    end
  end

  // line drive for the coming tick
  always_comb begin
    unique case (phase_d)
      PH_R_LOW, PH_W_LOW, PH_RD_LOW: pull_low = 1'b1;
      PH_W_HOLD:                     pull_low = ~shift_d[0];
      default:                       pull_low = 1'b0;
    endcase
  end

  assign res_o.pull_low = pull_low;
  assign res_o.busy     = (phase_d != PH_IDLE);
  assign res_o.done     = done;
  assign res_o.rx_byte  = rx_d;
  assign res_o.presence = pres_d;
  assign res_o.rejected = busy_in & is_start;

  // state update on each accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      bit_q   <= 3'd0;
      shift_q <= 8'h00;
      pres_q  <= 1'b0;
      rx_q    <= 8'h00;
    end else if (acc_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      pres_q  <= pres_d;
      rx_q    <= rx_d;
    end
  end

`ifndef SYNTHESIS
  // state only moves on an accepted transaction
  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc_i |=> $stable(phase_q) && $stable(tick_q) && $stable(rx_q))
    else $error("sequencer state changed without a transaction");

  // a start while idle always leaves the idle phase
  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && !busy_in && is_start |=> phase_q != PH_IDLE)
    else $error("start command did not begin an operation");

  // completion always returns to idle
  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && done |=> phase_q == PH_IDLE)
    else $error("operation completed but sequencer is not idle");
`endif

endmodule

[sv/onewire_bus_master.sv]
// The result of a transaction is registered and shown in the cycle after it is accepted.
// Throughput: one item per clock while a pending result is not held by out_ready_i low;
// the output register lets a new item in while a result is being taken.
// Reset (rst_ni low, asynchronous): sequencer idle, counters and bytes zero,
// presence clear, timing registers at their default values, output empty.
`timescale 1ns / 1ps

module onewire_bus_master import owb_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = DefCountWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             func_i,
  input  logic [7:0]             tx_byte_i,
  input  logic                   line_level_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   pull_low_o,
  output logic                   busy_res_o,
  output logic                   done_res_o,
  output logic [7:0]             rx_byte_o,
  output logic                   presence_o,
  output logic                   rejected_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [CfgWidth-1:0]    cfg_wdata_i
);

  owb_cfg_t cfg;
  owb_res_t res;
  owb_res_t res_q;
  logic     out_valid_q;
  logic     acc;

  // timing registers
  owb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // sequencer
  owb_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .acc_i        (acc),
    .func_i       (func_i),
    .tx_byte_i    (tx_byte_i),
    .line_level_i (line_level_i),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  // take a new transaction when the output slot is free or draining
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign acc        = in_valid_i & in_ready_o;

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pull_low_o  = res_q.pull_low;
  assign busy_res_o  = res_q.busy;
  assign done_res_o  = res_q.done;
  assign rx_byte_o   = res_q.rx_byte;
  assign presence_o  = res_q.presence;
  assign rejected_o  = res_q.rejected;

`ifndef SYNTHESIS
  // every accepted transaction yields a result in the next cycle
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted transaction produced no result");
`endif

endmodule
